// ===== hdl/assert_macros.svh =====
// assertion macros used by drt_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b at the same edge
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// property a implies b at the next edge
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== hdl/drt_pkg.sv =====
// shared types and constants for the dated rate table
// no dependencies
`default_nettype none
package drt_pkg;
    localparam int Entries = 1024;
    localparam int AW = $clog2(Entries);
    localparam int CW = AW + 1;
    localparam int KeyW = 23;
    localparam int RateW = 40;
    localparam logic [15:0] LimitReset = 16'd1000;
    localparam logic [13:0] MaxYear = 14'd9999;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_DATE = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_NEG_AMOUNT = 3'd3;
    localparam logic [2:0] ST_NO_RATE = 3'd4;
    localparam logic [2:0] ST_NEG_RATE = 3'd5;
    localparam logic [2:0] ST_FULL = 3'd6;

    localparam logic OP_LOAD = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture input word
        logic srch_init; // start binary search
        logic srch_step; // one probe read result
        logic rd_issue;  // issue read at mid, kept in r_mid
        logic sh_rd;     // read entry for shift
        logic sh_wr;     // write shifted entry
        logic ins_wr;    // write new entry at pos
        logic ovw_wr;    // overwrite rate at pos-1
        logic rd_rate;   // read rate at pos-1
        logic mul_lo;    // multiply partials
        logic mul_sum;   // form product
        logic res_load;  // load result register
        logic [2:0] res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic date_ok;
        logic neg_rate;
        logic too_large;
        logic neg_amt;
        logic srch_done;
        logic key_match;  // key at pos-1 equals key
        logic pos_zero;
        logic full;
        logic sh_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/drt_datapath.sv =====
// datapath: input capture, date check, table memories, search, shift, multiply
// depends on drt_pkg
`default_nettype none
module drt_datapath
    import drt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_op,
    input  wire logic [13:0]        i_year,
    input  wire logic [6:0]         i_month,
    input  wire logic [6:0]         i_day,
    input  wire logic signed [40:0] i_rate_in,
    input  wire logic signed [32:0] i_amount,
    input  wire logic [15:0]        i_limit,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic [2:0]              o_status,
    output logic [55:0]             o_product
);
    logic              r_op;
    logic [13:0]       r_year;
    logic [6:0]        r_month, r_day;
    logic [40:0]       r_rate;
    logic [32:0]       r_amt;
    logic [KeyW-1:0]   r_key;
    logic [KeyW-1:0]   r_kmem [Entries];
    logic [RateW-1:0]  r_rmem [Entries];
    logic [KeyW-1:0]   r_krd;
    logic [RateW-1:0]  r_rrd;
    logic [CW-1:0]     r_count, r_lo, r_hi, r_idx;
    logic [AW-1:0]     r_mid;
    logic              r_match;
    logic [55:0]       r_phi, r_plo, r_prod;
    logic [2:0]        r_status;
    logic [4:0]        mlen;
    logic              leap, dok;
    logic [26:0]       q_prod;
    logic [13:0]       cent_x100;
    logic [CW-1:0]     mid_w;
    logic [AW-1:0]     rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_op; r_year <= i_year; r_month <= i_month; r_day <= i_day;
            r_rate <= i_rate_in; r_amt <= i_amount;
        end
    end

    // leap: year mod 4 == 0 and (mod 100 != 0 or mod 400 == 0)
    // year / 100 by reciprocal multiply, exact over the 14-bit range
    always_comb begin
        q_prod = {13'd0, r_year} * 27'd5243;
        cent_x100 = {6'd0, q_prod[26:19]} * 14'd100;
        leap = (r_year[1:0] == 2'd0)
               && ((cent_x100 != r_year) || (r_year[3:0] == 4'd0));
        case (r_month)
            7'd2:    mlen = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11: mlen = 5'd30;
            default: mlen = 5'd31;
        endcase
        dok = (r_year <= MaxYear) && (r_month >= 7'd1) && (r_month <= 7'd12)
              && (r_day >= 7'd1) && (r_day <= {2'd0, mlen});
    end

    assign mid_w = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_addr = i_cmd.sh_rd ? r_idx[AW-1:0] - AW'(1)
                   : (i_cmd.rd_rate ? r_lo[AW-1:0] - AW'(1) : mid_w[AW-1:0]);

    // memories: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue || i_cmd.sh_rd || i_cmd.rd_rate) begin
            r_krd <= r_kmem[rd_addr];
            r_rrd <= r_rmem[rd_addr];
        end
        if (i_cmd.sh_wr) begin
            r_kmem[r_idx[AW-1:0]] <= r_krd;
            r_rmem[r_idx[AW-1:0]] <= r_rrd;
        end else if (i_cmd.ins_wr) begin
            r_kmem[r_lo[AW-1:0]] <= r_key;
            r_rmem[r_lo[AW-1:0]] <= r_rate[RateW-1:0];
        end else if (i_cmd.ovw_wr) begin
            r_rmem[r_lo[AW-1:0] - AW'(1)] <= r_rate[RateW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_wr) begin
            r_count <= r_count + CW'(1);
        end
    end

    // search keeps lo, hi; r_mid remembers probe; r_match tracks key at lo-1
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_key <= {r_year, r_month[3:0], r_day[4:0]};
            r_lo <= '0;
            r_hi <= r_count;
            r_match <= 1'b0;
        end else if (i_cmd.rd_issue) begin
            r_mid <= mid_w[AW-1:0];
        end else if (i_cmd.srch_step) begin
            if (r_krd <= r_key) begin
                r_lo <= {1'b0, r_mid} + CW'(1);
                r_match <= (r_krd == r_key);
            end else begin
                r_hi <= {1'b0, r_mid};
            end
        end
        if (i_cmd.srch_init) begin
            r_idx <= r_count;
        end else if (i_cmd.sh_wr) begin
            r_idx <= r_idx - CW'(1);
        end
    end

    // product split into a 33x20 and a 33x20 partial
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_phi <= 56'({23'd0, r_amt} * {36'd0, r_rrd[39:20]});
            r_plo <= 56'({23'd0, r_amt} * {36'd0, r_rrd[19:0]});
        end
        if (i_cmd.mul_sum) begin
            r_prod <= (r_phi << 4) + (r_plo >> 16);
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.date_ok   = dok;
        o_sts.neg_rate  = r_rate[40];
        o_sts.too_large = !r_amt[32] && (r_amt[31:0] > {i_limit, 16'd0});
        o_sts.neg_amt   = r_amt[32];
        o_sts.srch_done = (r_lo >= r_hi);
        o_sts.key_match = r_match;
        o_sts.pos_zero  = (r_lo == '0);
        o_sts.full      = (r_count == CW'(Entries));
        o_sts.sh_done   = (r_idx == r_lo);
    end

    assign o_status  = r_status;
    assign o_product = (r_status == ST_OK && r_op != OP_LOAD) ? r_prod : 56'd0;
endmodule
`default_nettype wire

// ===== hdl/drt_ctrl.sv =====
// controller: sequences check, search, shift or multiply per word
// depends on drt_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module drt_ctrl
    import drt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHECK = 11'b00000000010,
        S_PROBE = 11'b00000000100,
        S_WAIT  = 11'b00000001000,
        S_STEP  = 11'b00000010000,
        S_DEC   = 11'b00000100000,
        S_SHRD  = 11'b00001000000,
        S_SHWR  = 11'b00010000000,
        S_RATE  = 11'b00100000000,
        S_MUL   = 11'b01000000000,
        S_SUM   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   fire;

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign fire = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (fire) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.srch_init = 1'b1;
                o_cmd.res_load = 1'b1;
                n_state = S_IDLE;
                n_ovalid = 1'b1;
                if (!i_sts.date_ok) begin
                    o_cmd.res_status = ST_BAD_DATE;
                end else if (i_sts.op == OP_LOAD && i_sts.neg_rate) begin
                    o_cmd.res_status = ST_NEG_RATE;
                end else if (i_sts.op != OP_LOAD && i_sts.too_large) begin
                    o_cmd.res_status = ST_TOO_LARGE;
                end else if (i_sts.op != OP_LOAD && i_sts.neg_amt) begin
                    o_cmd.res_status = ST_NEG_AMOUNT;
                end else begin
                    o_cmd.res_load = 1'b0;
                    n_ovalid = 1'b0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.srch_done) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_STEP;
            S_STEP: begin
                o_cmd.srch_step = 1'b1;
                n_state = S_PROBE;
            end
            S_DEC: begin
                n_state = S_IDLE;
                if (i_sts.op == OP_LOAD) begin
                    if (!i_sts.pos_zero && i_sts.key_match) begin
                        o_cmd.ovw_wr = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_ovalid = 1'b1;
                    end else if (i_sts.full) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_ovalid = 1'b1;
                    end else if (i_sts.sh_done) begin
                        o_cmd.ins_wr = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_ovalid = 1'b1;
                    end else begin
                        n_state = S_SHRD;
                    end
                end else if (i_sts.pos_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_status = ST_NO_RATE;
                    n_ovalid = 1'b1;
                end else begin
                    o_cmd.rd_rate = 1'b1;
                    n_state = S_RATE;
                end
            end
            S_SHRD: begin
                o_cmd.sh_rd = 1'b1;
                n_state = S_SHWR;
            end
            S_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                n_state = S_DEC;
            end
            S_RATE: n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.mul_sum = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_status = ST_OK;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    `ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `ASSERT_NXT(a_fire_check, i_clk, i_rst_n, fire, r_state == S_CHECK)
    `ASSERT_IMP(a_one_write, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.sh_wr, o_cmd.ins_wr, o_cmd.ovw_wr}))
    `ASSERT_NXT(a_result_valid, i_clk, i_rst_n, o_cmd.res_load, o_valid)
endmodule
`default_nettype wire

// ===== hdl/dated_rate_table_floor_lookup.sv =====
// channel | signals                               | direction
// input   | i_valid o_ready i_op..i_amount         | in
// result  | o_valid i_ready o_status o_product     | out
// config  | psel penable pwrite paddr pwdata prdata| apb
// a word rejected by a check passes through idle and check; otherwise each probe of the
// binary search (up to 11) passes through probe, wait and step, and a last probe closes it;
// a load then decides and writes after a shift read and write per entry moved by an insert
// (up to count); a query reads the rate, multiplies and sums; single-port memory sets this
// reset is synchronous active low; table contents are undefined until loaded
// a new word is taken when idle and the previous result register is empty or being taken
// depends on drt_pkg, drt_ctrl, drt_datapath
`default_nettype none
module dated_rate_table_floor_lookup
    import drt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_op,
    input  wire logic [13:0]        i_year,
    input  wire logic [6:0]         i_month,
    input  wire logic [6:0]         i_day,
    input  wire logic signed [40:0] i_rate_in,
    input  wire logic signed [32:0] i_amount,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic [55:0]             o_product,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [15:0] r_limit;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_limit <= pwdata[15:0];
        end
    end
    assign prdata = (paddr == 2'd0) ? {16'd0, r_limit} : 32'd0;

    drt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(sts), .o_cmd(cmd)
    );

    drt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(i_op), .i_year(i_year),
        .i_month(i_month), .i_day(i_day), .i_rate_in(i_rate_in),
        .i_amount(i_amount), .i_limit(r_limit), .i_cmd(cmd), .o_sts(sts),
        .o_status(o_status), .o_product(o_product)
    );
endmodule
`default_nettype wire
